// File: rtl/cbls_pkg.sv
// ----------------------------------------------------------------------------
// cbls_pkg
// shared constants, codes and control types of the clone brush line stepper
// ----------------------------------------------------------------------------
package cbls_pkg;

  localparam int COORD_BITS  = 9;
  localparam int FRAC_BITS   = 16;
  localparam int MAX_SEGMENT = 64;

  localparam int OFF_BITS   = COORD_BITS + 1;
  localparam int SRC_BITS   = COORD_BITS + 2;
  localparam int DELTA_BITS = $clog2(MAX_SEGMENT);
  localparam int STEP_BITS  = FRAC_BITS + 2;
  localparam int ACC_BITS   = COORD_BITS + FRAC_BITS + 1;
  localparam int QUOT_BITS  = FRAC_BITS + 1;
  localparam int DIV_BITS   = DELTA_BITS + FRAC_BITS;

  typedef enum logic [1:0] {
    ACT_SET_SOURCE = 2'd0,
    ACT_PRESS      = 2'd1,
    ACT_MOVE       = 2'd2
  } action_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DECODE,
    ST_DIV_START,
    ST_DIV_WAIT,
    ST_RUN,
    ST_OVF
  } state_e;

  typedef struct packed {
    logic capture;
    logic set_anchor;
    logic clr_stroke;
    logic move_pen;
    logic walk_setup;
    logic div_start;
    logic load_step;
    logic load_pixel;
    logic load_ovf;
  } cmd_t;

  typedef struct packed {
    action_e action;
    logic    stroke;
    logic    src_valid;
    logic    too_long;
    logic    major_zero;
    logic    div_done;
    logic    out_free;
    logic    last_pixel;
  } status_t;

endpackage

// File: rtl/cbls_div.sv
// ----------------------------------------------------------------------------
// cbls_div
// restoring divider, one quotient bit per cycle, for the line slope
// ----------------------------------------------------------------------------
module cbls_div (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           start_i,
  input  logic [cbls_pkg::DELTA_BITS-1:0] num_i,
  input  logic [cbls_pkg::DELTA_BITS-1:0] den_i,
  output logic                           done_o,
  output logic [cbls_pkg::QUOT_BITS-1:0]  quot_o
);
  import cbls_pkg::*;

  localparam int CNT_W = $clog2(DIV_BITS);

  logic [DIV_BITS-1:0]   quo_q;
  logic [DELTA_BITS-1:0] rem_q;
  logic [CNT_W-1:0]      cnt_q;
  logic                  busy_q, done_q;
  logic [DELTA_BITS:0]   trial, diff;
  logic                  fits;

  // shift in the next dividend bit and try to subtract
  assign trial = {rem_q, quo_q[DIV_BITS-1]};
  assign fits  = trial >= {1'b0, den_i};
  assign diff  = trial - {1'b0, den_i};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CNT_W'(DIV_BITS - 1);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == '0) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q <= {num_i, {FRAC_BITS{1'b0}}};
      rem_q <= '0;
    end else if (busy_q) begin
      quo_q <= {quo_q[DIV_BITS-2:0], fits};
      rem_q <= fits ? diff[DELTA_BITS-1:0] : trial[DELTA_BITS-1:0];
    end
  end

  assign done_o = done_q;
  assign quot_o = quo_q[QUOT_BITS-1:0];

endmodule

// File: rtl/cbls_datapath.sv
// ----------------------------------------------------------------------------
// cbls_datapath
// brush state, line setup, slope divider, dda walk and result register
// ----------------------------------------------------------------------------
module cbls_datapath (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  cbls_pkg::cmd_t                  cmd_i,
  output cbls_pkg::status_t               status_o,
  input  logic [1:0]                      action_i,
  input  logic [cbls_pkg::COORD_BITS-1:0] pos_x_i,
  input  logic [cbls_pkg::COORD_BITS-1:0] pos_y_i,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output logic [cbls_pkg::COORD_BITS-1:0] dst_x_o,
  output logic [cbls_pkg::COORD_BITS-1:0] dst_y_o,
  output logic signed [cbls_pkg::SRC_BITS-1:0] src_x_o,
  output logic signed [cbls_pkg::SRC_BITS-1:0] src_y_o,
  output logic                            last_o,
  output logic                            overflow_o
);
  import cbls_pkg::*;

  // captured input
  action_e               act_q;
  logic [COORD_BITS-1:0] px_q, py_q;

  // brush state
  logic                  source_valid_q, offset_latched_q, stroke_q;
  logic [COORD_BITS-1:0] anchor_x_q, anchor_y_q, pen_x_q, pen_y_q;
  logic [OFF_BITS-1:0]   offset_x_q, offset_y_q;

  // walk state
  logic                  horiz_q, dneg_q;
  logic [COORD_BITS-1:0] a_q;
  logic [ACC_BITS-1:0]   acc_q;
  logic [STEP_BITS-1:0]  step_q;
  logic [DELTA_BITS-1:0] cnt_q, dmag_q;

  // result register
  logic                  out_valid_q, last_q, ovf_q;
  logic [COORD_BITS-1:0] dst_x_q, dst_y_q;
  logic [SRC_BITS-1:0]   src_x_q, src_y_q;

  // line setup
  logic                  x_lt, y_lt, horiz, swap, dneg, out_free, div_done;
  logic [COORD_BITS-1:0] adx, ady, major, sx, sy, ex, ey, minor0, minor_end, dmag;
  logic                  setup_horiz;
  logic [COORD_BITS-1:0] setup_major, setup_minor0, setup_a;
  logic [QUOT_BITS-1:0]  quot;
  logic [STEP_BITS-1:0]  quot_ext;

  // pixel formation
  logic [COORD_BITS-1:0] pix_m, pix_x, pix_y;
  logic [OFF_BITS-1:0]   new_off_x, new_off_y, eff_off_x, eff_off_y;

  always_comb begin
    x_lt      = px_q < pen_x_q;
    y_lt      = py_q < pen_y_q;
    adx       = x_lt ? pen_x_q - px_q : px_q - pen_x_q;
    ady       = y_lt ? pen_y_q - py_q : py_q - pen_y_q;
    horiz     = adx > ady;
    major     = horiz ? adx : ady;
    swap      = horiz ? x_lt : y_lt;
    sx        = swap ? px_q : pen_x_q;
    ex        = swap ? pen_x_q : px_q;
    sy        = swap ? py_q : pen_y_q;
    ey        = swap ? pen_y_q : py_q;
    minor0    = horiz ? sy : sx;
    minor_end = horiz ? ey : ex;
    dneg      = minor_end < minor0;
    dmag      = dneg ? minor0 - minor_end : minor_end - minor0;
    // a press walks a one-pixel vertical line
    if (act_q == ACT_PRESS) begin
      setup_horiz  = 1'b0;
      setup_major  = '0;
      setup_minor0 = px_q;
      setup_a      = py_q;
    end else begin
      setup_horiz  = horiz;
      setup_major  = major;
      setup_minor0 = minor0;
      setup_a      = horiz ? sx : sy;
    end
  end

  cbls_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cmd_i.div_start),
    .num_i   (dmag_q),
    .den_i   (cnt_q),
    .done_o  (div_done),
    .quot_o  (quot)
  );

  assign quot_ext = {1'b0, quot};
  assign out_free = !out_valid_q || !out_stall_i;

  always_comb begin
    pix_m     = acc_q[FRAC_BITS +: COORD_BITS];
    pix_x     = horiz_q ? a_q : pix_m;
    pix_y     = horiz_q ? pix_m : a_q;
    new_off_x = OFF_BITS'({1'b0, pix_x} - {1'b0, anchor_x_q});
    new_off_y = OFF_BITS'({1'b0, pix_y} - {1'b0, anchor_y_q});
    eff_off_x = offset_latched_q ? offset_x_q : new_off_x;
    eff_off_y = offset_latched_q ? offset_y_q : new_off_y;
  end

  always_comb begin
    status_o.action     = act_q;
    status_o.stroke     = stroke_q;
    status_o.src_valid  = source_valid_q;
    status_o.too_long   = int'(setup_major) >= MAX_SEGMENT;
    status_o.major_zero = setup_major == '0;
    status_o.div_done   = div_done;
    status_o.out_free   = out_free;
    status_o.last_pixel = cnt_q == '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      source_valid_q   <= 1'b0;
      offset_latched_q <= 1'b0;
      stroke_q         <= 1'b0;
      anchor_x_q       <= '0;
      anchor_y_q       <= '0;
      pen_x_q          <= '0;
      pen_y_q          <= '0;
      offset_x_q       <= '0;
      offset_y_q       <= '0;
      out_valid_q      <= 1'b0;
    end else begin
      if (cmd_i.set_anchor) begin
        source_valid_q   <= 1'b1;
        offset_latched_q <= 1'b0;
        stroke_q         <= 1'b1;
        anchor_x_q       <= px_q;
        anchor_y_q       <= py_q;
      end
      if (cmd_i.clr_stroke) begin
        stroke_q <= 1'b0;
      end
      if (cmd_i.move_pen) begin
        pen_x_q <= px_q;
        pen_y_q <= py_q;
      end
      if (cmd_i.load_pixel && !offset_latched_q) begin
        offset_latched_q <= 1'b1;
        offset_x_q       <= new_off_x;
        offset_y_q       <= new_off_y;
      end
      if (cmd_i.load_pixel || cmd_i.load_ovf) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      act_q <= action_e'(action_i);
      px_q  <= pos_x_i;
      py_q  <= pos_y_i;
    end
    if (cmd_i.walk_setup) begin
      horiz_q <= setup_horiz;
      a_q     <= setup_a;
      acc_q   <= {1'b0, setup_minor0, 1'b1, {(FRAC_BITS-1){1'b0}}};
      step_q  <= '0;
      cnt_q   <= setup_major[DELTA_BITS-1:0];
      dmag_q  <= dmag[DELTA_BITS-1:0];
      dneg_q  <= dneg;
    end else if (cmd_i.load_step) begin
      step_q <= dneg_q ? STEP_BITS'(-quot_ext) : quot_ext;
    end else if (cmd_i.load_pixel) begin
      a_q   <= a_q + 1'b1;
      acc_q <= acc_q + {{(ACC_BITS-STEP_BITS){step_q[STEP_BITS-1]}}, step_q};
      cnt_q <= cnt_q - 1'b1;
    end
    if (cmd_i.load_pixel) begin
      dst_x_q <= pix_x;
      dst_y_q <= pix_y;
      src_x_q <= {2'b00, pix_x} - {eff_off_x[OFF_BITS-1], eff_off_x};
      src_y_q <= {2'b00, pix_y} - {eff_off_y[OFF_BITS-1], eff_off_y};
      last_q  <= cnt_q == '0;
      ovf_q   <= 1'b0;
    end else if (cmd_i.load_ovf) begin
      dst_x_q <= '0;
      dst_y_q <= '0;
      src_x_q <= '0;
      src_y_q <= '0;
      last_q  <= 1'b1;
      ovf_q   <= 1'b1;
    end
  end

  assign out_valid_o = out_valid_q;
  assign dst_x_o     = dst_x_q;
  assign dst_y_o     = dst_y_q;
  assign src_x_o     = src_x_q;
  assign src_y_o     = src_y_q;
  assign last_o      = last_q;
  assign overflow_o  = ovf_q;

  a_load_needs_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.load_pixel || cmd_i.load_ovf) |-> out_free)
    else $error("result loaded while output register is busy");

  a_pixel_latches_offset: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.load_pixel |=> offset_latched_q)
    else $error("offset not latched after a painted pixel");

  a_anchor_clears_offset: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.set_anchor |=> (source_valid_q && !offset_latched_q && stroke_q))
    else $error("source anchor did not reset offset state");

endmodule

// File: rtl/cbls_ctrl.sv
// ----------------------------------------------------------------------------
// cbls_ctrl
// sequencer: decode an event, slope divide if needed, then step the pixels
// ----------------------------------------------------------------------------
module cbls_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  cbls_pkg::status_t   status_i,
  output cbls_pkg::cmd_t      cmd_o
);
  import cbls_pkg::*;

  state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) state_d = ST_DECODE;
      end
      ST_DECODE: begin
        case (status_i.action)
          ACT_SET_SOURCE: state_d = ST_IDLE;
          ACT_PRESS:      state_d = status_i.src_valid ? ST_RUN : ST_IDLE;
          ACT_MOVE: begin
            if (status_i.stroke || !status_i.src_valid) state_d = ST_IDLE;
            else if (status_i.too_long)                 state_d = ST_OVF;
            else if (status_i.major_zero)               state_d = ST_RUN;
            else                                        state_d = ST_DIV_START;
          end
          default:        state_d = ST_IDLE;
        endcase
      end
      ST_DIV_START: state_d = ST_DIV_WAIT;
      ST_DIV_WAIT: begin
        if (status_i.div_done) state_d = ST_RUN;
      end
      ST_RUN: begin
        if (status_i.out_free && status_i.last_pixel) state_d = ST_IDLE;
      end
      ST_OVF: begin
        if (status_i.out_free) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o      = '0;
    in_stall_o = 1'b1;
    unique case (state_q)
      ST_IDLE: begin
        in_stall_o    = 1'b0;
        cmd_o.capture = in_valid_i;
      end
      ST_DECODE: begin
        cmd_o.walk_setup = 1'b1;
        cmd_o.set_anchor = status_i.action == ACT_SET_SOURCE;
        cmd_o.clr_stroke = status_i.action == ACT_PRESS;
        cmd_o.move_pen   = (status_i.action == ACT_SET_SOURCE) ||
                           (status_i.action == ACT_PRESS) ||
                           (status_i.action == ACT_MOVE && !status_i.stroke);
      end
      ST_DIV_START: cmd_o.div_start  = 1'b1;
      ST_DIV_WAIT:  cmd_o.load_step  = status_i.div_done;
      ST_RUN:       cmd_o.load_pixel = status_i.out_free;
      ST_OVF:       cmd_o.load_ovf   = status_i.out_free;
      default:      cmd_o = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  a_accept_decodes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> state_q == ST_DECODE)
    else $error("accepted transaction not decoded");

  a_div_then_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DIV_WAIT && status_i.div_done) |=> state_q == ST_RUN)
    else $error("slope ready but walk not started");

  a_last_pixel_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_o.load_pixel && status_i.last_pixel) |=> state_q == ST_IDLE)
    else $error("walk continued past its last pixel");

endmodule

// File: rtl/clone_brush_line_stepper_top.sv
// ----------------------------------------------------------------------------
// clone_brush_line_stepper_top
// turns pointer events into clone brush pixel-copy requests along dda lines
// ----------------------------------------------------------------------------
//
// channel  | direction | handshake                    | payload
// ---------+-----------+------------------------------+------------------------
// in       | input     | in_valid_i / in_stall_o      | action, pos_x, pos_y
// out      | output    | out_valid_o / out_stall_i    | dst_x/y, src_x/y, last,
//          |           |                              | overflow
//
// one event is worked at a time; a transaction is taken, decoded the next
// cycle, then its results leave one per cycle through the output register
// while the output is not stalled; a press walks one pixel, and a move with
// major delta n walks n + 1 pixels, after the bit-serial slope divider has
// run when n is nonzero
// a set-source event, an ignored code, a drag after set-source or an event with
// no anchor yields no result; an overflow move yields one overflow result
// reset clears the brush state (no anchor, no offset, pen at the origin)
// a stalled output holds the walk or the overflow result; the next input
// transaction is taken once the current one has loaded its last result
//
module clone_brush_line_stepper_top (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  logic [1:0]                      action_i,
  input  logic [cbls_pkg::COORD_BITS-1:0] pos_x_i,
  input  logic [cbls_pkg::COORD_BITS-1:0] pos_y_i,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output logic [cbls_pkg::COORD_BITS-1:0] dst_x_o,
  output logic [cbls_pkg::COORD_BITS-1:0] dst_y_o,
  output logic signed [cbls_pkg::SRC_BITS-1:0] src_x_o,
  output logic signed [cbls_pkg::SRC_BITS-1:0] src_y_o,
  output logic                            last_o,
  output logic                            overflow_o
);
  import cbls_pkg::*;

  // command and status between sequencer and datapath
  cmd_t    cmd;
  status_t status;

  cbls_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  // datapath holds the brush state, the walk and the result register
  cbls_datapath u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .status_o    (status),
    .action_i    (action_i),
    .pos_x_i     (pos_x_i),
    .pos_y_i     (pos_y_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .dst_x_o     (dst_x_o),
    .dst_y_o     (dst_y_o),
    .src_x_o     (src_x_o),
    .src_y_o     (src_y_o),
    .last_o      (last_o),
    .overflow_o  (overflow_o)
  );

endmodule
